FILE: rtl/usc_pkg.sv
// Shared constants and helpers for the Unix seconds to calendar converter.
package usc_pkg;

  localparam int unsigned SecsW     = 32;
  localparam int unsigned DateW     = 25;
  localparam int unsigned TimeW     = 18;
  localparam int unsigned DaysW     = 16;
  localparam int unsigned TodW      = 17;
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned EpochYear  = 1970;
  localparam int unsigned DaysPer400 = 146097;
  localparam int unsigned InW       = 32;
  localparam int unsigned OutW      = 48;
  localparam int unsigned PipeDepth = 7;

  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
    logic             zero;
  } split_t;

  typedef struct packed {
    logic [DateW-1:0] date_code;
    logic [TimeW-1:0] time_code;
  } result_t;

endpackage

FILE: rtl/usc_split.sv
// First pipeline stages: split seconds into whole days and time of day.
module usc_split (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [usc_pkg::SecsW-1:0] secs_i,
  output usc_pkg::split_t          split_o
);

  // Stage A: approximate day count by reciprocal multiply of secs >> 7 by 86400/128 = 675.
  logic [usc_pkg::SecsW-1:0] secs_q;
  logic [usc_pkg::DaysW-1:0] qest_q;
  logic [56:0]               prod;
  logic [usc_pkg::DaysW-1:0] qest_d;

  // 2^40 / 675 rounded down, error keeps the estimate within one below.
  localparam logic [31:0] Recip = 32'd1628906115;

  assign prod   = {25'd0, secs_i[31:7]} * {25'd0, Recip};
  assign qest_d = prod[55:40];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secs_q <= '0;
      qest_q <= '0;
    end else if (en_i) begin
      secs_q <= secs_i;
      qest_q <= qest_d;
    end
  end

  logic [33:0] rem;
  logic [33:0] qprod;
  assign qprod = {18'd0, qest_q} * 34'(usc_pkg::SecsPerDay);
  assign rem   = {2'd0, secs_q} - qprod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_o <= '0;
    end else if (en_i) begin
      if (rem >= 34'(usc_pkg::SecsPerDay)) begin
        split_o.days <= qest_q + 16'd1;
        split_o.tod  <= usc_pkg::TodW'(rem - 34'(usc_pkg::SecsPerDay));
      end else begin
        split_o.days <= qest_q;
        split_o.tod  <= usc_pkg::TodW'(rem);
      end
      split_o.zero <= (secs_q == '0);
    end
  end

endmodule

FILE: rtl/usc_civil.sv
// Later pipeline stages: civil date from day count and clock fields from time of day.
module usc_civil (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  usc_pkg::split_t           split_i,
  output usc_pkg::result_t          res_o
);

  // Stage C: shift to 0000-03-01 era days, split era and day of era.
  logic [19:0] z_c;
  assign z_c = 20'(split_i.days) + 20'd135080;  // 719468 - 584388 (era 4 base)

  logic [19:0] doe_q;
  logic        era_q;
  logic [16:0] tod_c_q;
  logic        zero_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doe_q <= '0; era_q <= 1'b0; tod_c_q <= '0; zero_c_q <= 1'b0;
    end else if (en_i) begin
      if (z_c >= 20'(usc_pkg::DaysPer400)) begin
        doe_q <= z_c - 20'(usc_pkg::DaysPer400);
        era_q <= 1'b1;
      end else begin
        doe_q <= z_c;
        era_q <= 1'b0;
      end
      tod_c_q  <= split_i.tod;
      zero_c_q <= split_i.zero;
    end
  end

  // Stage D: year of era numerator (doe - doe/1460 + doe/36524 - doe/146096), hour.
  logic [17:0] d1460, d36524;
  logic [37:0] m1460;
  logic        d146096;
  assign m1460   = {18'd0, doe_q} * 38'd183860;   // 2^28/1460 rounded up
  assign d1460   = 18'(m1460 >> 28);
  assign d36524  = 18'(doe_q >= 20'd36524) + 18'(doe_q >= 20'd73048) +
                   18'(doe_q >= 20'd109572) + 18'(doe_q >= 20'd146096);
  assign d146096 = (doe_q == 20'd146096);

  logic [31:0] hp;
  assign hp = 32'(tod_c_q) * 32'd37283;           // /3600 via 2^27

  logic [17:0] yn_q;
  logic [19:0] doe_d_q;
  logic        era_d_q;
  logic [16:0] tod_d_q;
  logic [4:0]  hour_d_q;
  logic        zero_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yn_q <= '0; doe_d_q <= '0; era_d_q <= 1'b0; tod_d_q <= '0; hour_d_q <= '0;
      zero_d_q <= 1'b0;
    end else if (en_i) begin
      yn_q     <= 18'(doe_q - 20'(d1460) + 20'(d36524) - {19'd0, d146096});
      doe_d_q  <= doe_q;
      era_d_q  <= era_q;
      tod_d_q  <= tod_c_q;
      hour_d_q <= 5'(hp >> 27);
      zero_d_q <= zero_c_q;
    end
  end

  // Stage E: year of era and seconds within the hour.
  logic [37:0] myoe;
  logic [16:0] hsec;
  assign myoe = {20'd0, yn_q} * 38'd735440;       // 2^28/365 rounded up
  assign hsec = 17'(hour_d_q) * 17'd3600;

  logic [8:0]  yoe_q;
  logic [11:0] rs_q;
  logic [19:0] doe_e_q;
  logic        era_e_q;
  logic [4:0]  hour_e_q;
  logic        zero_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yoe_q <= '0; rs_q <= '0; doe_e_q <= '0; era_e_q <= 1'b0; hour_e_q <= '0;
      zero_e_q <= 1'b0;
    end else if (en_i) begin
      yoe_q    <= 9'(myoe >> 28);
      rs_q     <= 12'(tod_d_q - hsec);
      doe_e_q  <= doe_d_q;
      era_e_q  <= era_d_q;
      hour_e_q <= hour_d_q;
      zero_e_q <= zero_d_q;
    end
  end

  // Stage F: year, day of year, month index, minute and second.
  logic [1:0]  ycent;
  logic [19:0] yd;
  logic [8:0]  doy;
  assign ycent = 2'(yoe_q >= 9'd100) + 2'(yoe_q >= 9'd200) + 2'(yoe_q >= 9'd300);
  assign yd    = 20'(yoe_q) * 20'd365 + 20'(yoe_q >> 2) - 20'(ycent);
  assign doy   = 9'(doe_e_q - yd);

  logic [3:0]  mp;
  logic [13:0] mpn;
  assign mpn = 14'(doy) * 14'd5 + 14'd2;
  assign mp  = 4'((22'(mpn) * 22'd1714) >> 18);   // /153 for values under 1840

  logic [5:0]  minute, second;
  assign minute = 6'((24'(rs_q) * 24'd4370) >> 18);
  assign second = 6'(rs_q - 12'(minute) * 12'd60);

  logic [11:0] year_q;
  logic [3:0]  mp_q;
  logic [8:0]  doy_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q, sec_q;
  logic        zero_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= '0; mp_q <= '0; doy_q <= '0; hour_q <= '0;
      min_q <= '0; sec_q <= '0; zero_f_q <= 1'b0;
    end else if (en_i) begin
      year_q   <= 12'd1600 + (era_e_q ? 12'd400 : 12'd0) + 12'(yoe_q);
      mp_q     <= mp;
      doy_q    <= doy;
      hour_q   <= hour_e_q;
      min_q    <= minute;
      sec_q    <= second;
      zero_f_q <= zero_e_q;
    end
  end

  // Stage G: month, day and decimal packing.
  logic [13:0] mdn;
  logic [8:0]  dstart;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [11:0] year;
  assign mdn    = 14'(mp_q) * 14'd153 + 14'd2;
  assign dstart = 9'((22'(mdn) * 22'd1639) >> 13);     // /5
  assign day    = 5'(doy_q - dstart + 9'd1);
  assign month  = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
  assign year   = (month <= 4'd2) ? year_q + 12'd1 : year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o <= '0;
    end else if (en_i) begin
      if (zero_f_q) begin
        res_o <= '0;
      end else begin
        res_o.date_code <= 25'(year) * 25'd10000 + 25'(month) * 25'd100 + 25'(day);
        res_o.time_code <= 18'(hour_q) * 18'd10000 + 18'(min_q) * 18'd100 + 18'(sec_q);
      end
    end
  end

endmodule

FILE: rtl/unix_seconds_to_calendar.sv
// Top level of the Unix seconds to calendar date and time converter.
// Each beat of 32-bit Unix seconds yields one beat carrying the UTC date as
// year*10000+month*100+day and the time as hour*10000+minute*100+second; zero
// input gives zero on both. The converter is a seven-stage pipeline that takes
// one beat per cycle; the whole pipeline holds while the output is stalled, and
// valid bits travel with the data.
module unix_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // unix_seconds[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // date_code[24:0], time_code[42:25], zero pad
);

  logic [usc_pkg::PipeDepth-1:0] vld_q;
  logic                          en;
  usc_pkg::split_t               split;
  usc_pkg::result_t              res;

  assign en            = !vld_q[usc_pkg::PipeDepth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[usc_pkg::PipeDepth-1];
  assign m_axis_tdata  = {5'd0, res.time_code, res.date_code};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[usc_pkg::PipeDepth-2:0], s_axis_tvalid};
    end
  end

  usc_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .secs_i  (s_axis_tdata),
    .split_o (split)
  );

  usc_civil u_civil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .split_i (split),
    .res_o   (res)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24:0] == 25'd0 |-> m_axis_tdata[42:25] == 18'd0)
    else $error("zero date with nonzero time");

endmodule

FILE: bench/tb_top.sv
// Testbench for the Unix seconds to calendar converter: random and directed beats checked against a predictor.
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  typedef struct {
    logic [24:0] date_code;
    logic [17:0] time_code;
  } calendar_t;

  logic [31:0] pending_secs[$];
  calendar_t   expected_dates[$];
  int          errors = 0;
  int          beats_out = 0;
  int          hold_cycles = 0;
  int          gap_cycles = 0;
  bit          stim_done = 1'b0;
  bit          sender_pause = 1'b0;
  int          sent = 0;

  unix_seconds_to_calendar uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic calendar_t civil_from_secs(logic [31:0] secs);
    calendar_t   r;
    int unsigned days, tod, yr, mon, mlen;
    int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (secs == 0) begin
      r.date_code = '0;
      r.time_code = '0;
      return r;
    end
    days = secs / 86400;
    tod  = secs % 86400;
    yr   = 1970;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days -= leap_year(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    for (int i = 0; i < 12; i++) begin
      mlen = (i == 1 && leap_year(yr)) ? 29 : mdays[i];
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    r.date_code = 25'(yr * 10000 + mon * 100 + days + 1);
    r.time_code = 18'((tod / 3600) * 10000 + ((tod % 3600) / 60) * 100 + tod % 60);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sender: offers beats from the pending queue with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(civil_from_secs(s_axis_tdata));
        sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_cycles > 0) begin
          gap_cycles--;
          s_axis_tvalid <= 1'b0;
        end else if (sender_pause || pending_secs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_secs.pop_front();
          gap_cycles    = pick_gap();
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off, checks each beat.
  always @(posedge clk_i) begin
    calendar_t got;
    calendar_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.date_code = m_axis_tdata[24:0];
        got.time_code = m_axis_tdata[42:25];
        beats_out++;
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected beat date %0d time %0d", $time,
                   got.date_code, got.time_code);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          if (got.date_code !== want.date_code) begin
            $display("%0t: date_code expected %0d actual %0d", $time,
                     want.date_code, got.date_code);
            errors++;
          end
          if (got.time_code !== want.time_code) begin
            $display("%0t: time_code expected %0d actual %0d", $time,
                     want.time_code, got.time_code);
            errors++;
          end
          if (m_axis_tdata[47:43] !== 5'd0) begin
            $display("%0t: pad expected 0 actual %0h", $time, m_axis_tdata[47:43]);
            errors++;
          end
        end
      end
      if (beats_out == 300 && hold_cycles == 0) hold_cycles = 200;
      if (hold_cycles > 1) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        if (hold_cycles == 1) hold_cycles = -1;
        m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                         ($urandom_range(0, 9) == 0 && $urandom_range(0, 1) == 1);
      end
    end
  end

  function automatic logic [31:0] secs_of(int unsigned y, int unsigned m, int unsigned d,
                                           int unsigned hh, int unsigned mm, int unsigned ss);
    longint unsigned days;
    int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    days = 0;
    for (int unsigned yy = 1970; yy < y; yy++) days += leap_year(yy) ? 366 : 365;
    for (int unsigned i = 0; i + 1 < m; i++) days += (i == 1 && leap_year(y)) ? 29 : mdays[i];
    days += d - 1;
    return 32'(days * 86400 + hh * 3600 + mm * 60 + ss);
  endfunction

  initial begin
    logic [31:0] v;
    int unsigned y, m;
    pending_secs.push_back(32'd0);
    pending_secs.push_back(32'd1);
    pending_secs.push_back(32'hFFFF_FFFF);
    pending_secs.push_back(32'hFFFF_FFFE);
    pending_secs.push_back(32'h8000_0000);
    pending_secs.push_back(32'h7FFF_FFFF);
    pending_secs.push_back(32'd86399);
    pending_secs.push_back(32'd86400);
    pending_secs.push_back(secs_of(1972, 2, 29, 23, 59, 59));
    pending_secs.push_back(secs_of(1972, 3, 1, 0, 0, 0));
    pending_secs.push_back(secs_of(1999, 12, 31, 23, 59, 59));
    pending_secs.push_back(secs_of(2000, 2, 29, 12, 0, 0));
    pending_secs.push_back(secs_of(2000, 12, 31, 0, 0, 0));
    pending_secs.push_back(secs_of(2100, 2, 28, 23, 59, 59));
    pending_secs.push_back(secs_of(2100, 3, 1, 0, 0, 0));
    pending_secs.push_back(secs_of(2106, 2, 7, 6, 28, 15));
    pending_secs.push_back(secs_of(1970, 12, 31, 23, 59, 59));
    pending_secs.push_back(secs_of(1971, 1, 1, 0, 0, 0));
    pending_secs.push_back(32'h5555_5555);
    pending_secs.push_back(32'hAAAA_AAAA);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_secs.size() == 0);
    @(posedge clk_i);
    sender_pause = 1'b1;
    wait (expected_dates.size() == 0 && !s_axis_tvalid);
    repeat (10) @(posedge clk_i);
    sender_pause = 1'b0;
    for (int i = 0; i < 1800; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom();
        1: begin
          y = $urandom_range(1970, 2105);
          m = $urandom_range(1, 12);
          v = secs_of(y, m, 1, 0, 0, 0) - 32'($urandom_range(0, 1));
        end
        2: v = secs_of($urandom_range(1970, 2105), 3, 1, 0, 0, 0)
               - 32'($urandom_range(0, 86400 * 2));
        default: v = $urandom_range(0, 1) ? 32'($urandom_range(0, 200))
                                         : ~32'($urandom_range(0, 200));
      endcase
      if (v == 0 && i % 7 != 0) v = 32'd1;
      pending_secs.push_back(v);
    end
    wait (pending_secs.size() == 0);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    wait (!s_axis_tvalid && expected_dates.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d beats, received %0d: epoch, leap days, century and 32-bit", sent,
             beats_out);
    $display("limits, month ends, and long output stalls were exercised.");
    if (errors == 0 && expected_dates.size() == 0) begin
      $display("unix_seconds_to_calendar test passed");
    end else begin
      $display("unix_seconds_to_calendar test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("unix_seconds_to_calendar test failed");
    $finish;
  end

endmodule
